[src/tpi_pkg.sv]
// Shared types and constants for the three-plane intersection block.
`default_nettype none

package tpi_pkg;

  localparam int VALUE_BITS = 24;
  localparam int FRAC_BITS = 12;
  localparam int CROSS_BITS = 2 * VALUE_BITS + 1;
  localparam int HIGH_BITS = CROSS_BITS - VALUE_BITS;
  localparam int PART_BITS = HIGH_BITS + VALUE_BITS;
  localparam int PROD_BITS = VALUE_BITS + CROSS_BITS;
  localparam int SUM_BITS = PROD_BITS + 2;
  localparam int REM_BITS = SUM_BITS + VALUE_BITS;
  localparam int QUO_BITS = VALUE_BITS - 1;
  localparam int FRONT_STAGES = 5;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS = 2;

  typedef logic signed [VALUE_BITS-1:0] val_t;

  localparam val_t VAL_MAX = {1'b0, {QUO_BITS{1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {QUO_BITS{1'b0}}};

  typedef struct packed {
    val_t p1_nx;
    val_t p1_ny;
    val_t p1_nz;
    val_t p1_dist;
    val_t p2_nx;
    val_t p2_ny;
    val_t p2_nz;
    val_t p2_dist;
    val_t p3_nx;
    val_t p3_ny;
    val_t p3_nz;
    val_t p3_dist;
  } in_t;

  typedef struct packed {
    val_t pos_x;
    val_t pos_y;
    val_t pos_z;
    logic degenerate;
  } out_t;

  typedef struct packed {
    logic [SUM_BITS-1:0] num_x;
    logic [SUM_BITS-1:0] num_y;
    logic [SUM_BITS-1:0] num_z;
    logic [SUM_BITS-1:0] den;
    logic degenerate;
  } mid_t;

endpackage

`default_nettype wire

[src/tpi_front.sv]
// Front pipeline: cross products, triple product and numerators, exact.
`default_nettype none

module tpi_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  tpi_pkg::in_t  planes,
  output logic          mid_valid,
  input  logic          mid_ready,
  output tpi_pkg::mid_t mid
);

  logic [tpi_pkg::FRONT_STAGES-1:0] vld;
  logic en;

  tpi_pkg::val_t nv [3][3];
  tpi_pkg::val_t dv [3];

  logic signed [2*tpi_pkg::VALUE_BITS-1:0] s1_p [3][3][2];
  tpi_pkg::val_t s1_n1 [3];
  tpi_pkg::val_t s1_d [3];

  logic signed [tpi_pkg::CROSS_BITS-1:0] s2_c [3][3];
  tpi_pkg::val_t s2_n1 [3];
  tpi_pkg::val_t s2_d [3];

  logic signed [tpi_pkg::CROSS_BITS-1:0] cv [4][3];
  tpi_pkg::val_t mv [4][3];

  logic signed [tpi_pkg::PART_BITS-1:0] s3_ph [4][3];
  logic signed [tpi_pkg::PART_BITS-1:0] s3_pl [4][3];
  logic signed [tpi_pkg::PROD_BITS-1:0] s4_p [4][3];
  logic signed [tpi_pkg::SUM_BITS-1:0] s5_s [4];

  assign en = mid_ready || !vld[tpi_pkg::FRONT_STAGES-1];
  assign full = !en;
  assign mid_valid = vld[tpi_pkg::FRONT_STAGES-1];

  always_comb begin
    nv[0][0] = planes.p1_nx;
    nv[0][1] = planes.p1_ny;
    nv[0][2] = planes.p1_nz;
    nv[1][0] = planes.p2_nx;
    nv[1][1] = planes.p2_ny;
    nv[1][2] = planes.p2_nz;
    nv[2][0] = planes.p3_nx;
    nv[2][1] = planes.p3_ny;
    nv[2][2] = planes.p3_nz;
    dv[0] = planes.p1_dist;
    dv[1] = planes.p2_dist;
    dv[2] = planes.p3_dist;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[tpi_pkg::FRONT_STAGES-2:0], push};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int cr = 0; cr < 3; cr++) begin
        for (int k = 0; k < 3; k++) begin
          s1_p[cr][k][0] <= nv[(cr+1)%3][(k+1)%3] * nv[(cr+2)%3][(k+2)%3];
          s1_p[cr][k][1] <= nv[(cr+1)%3][(k+2)%3] * nv[(cr+2)%3][(k+1)%3];
        end
      end
      for (int k = 0; k < 3; k++) begin
        s1_n1[k] <= nv[0][k];
        s1_d[k] <= dv[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int cr = 0; cr < 3; cr++) begin
        for (int k = 0; k < 3; k++) begin
          s2_c[cr][k] <= tpi_pkg::CROSS_BITS'(s1_p[cr][k][0])
                       - tpi_pkg::CROSS_BITS'(s1_p[cr][k][1]);
        end
      end
      s2_n1 <= s1_n1;
      s2_d <= s1_d;
    end
  end

  // Row zero forms the triple product terms, rows one to three the numerator terms.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cv[0][i] = s2_c[0][i];
      mv[0][i] = s2_n1[i];
      for (int r = 1; r < 4; r++) begin
        cv[r][i] = s2_c[i][r-1];
        mv[r][i] = s2_d[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int i = 0; i < 3; i++) begin
          s3_ph[r][i] <= $signed(cv[r][i][tpi_pkg::CROSS_BITS-1:tpi_pkg::VALUE_BITS])
                       * mv[r][i];
          s3_pl[r][i] <= $signed({1'b0, cv[r][i][tpi_pkg::VALUE_BITS-1:0]}) * mv[r][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int i = 0; i < 3; i++) begin
          s4_p[r][i] <= (tpi_pkg::PROD_BITS'(s3_ph[r][i]) <<< tpi_pkg::VALUE_BITS)
                      + tpi_pkg::PROD_BITS'(s3_pl[r][i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        s5_s[r] <= tpi_pkg::SUM_BITS'(s4_p[r][0]) + tpi_pkg::SUM_BITS'(s4_p[r][1])
                 + tpi_pkg::SUM_BITS'(s4_p[r][2]);
      end
    end
  end

  always_comb begin
    mid.den = s5_s[0];
    mid.num_x = s5_s[1];
    mid.num_y = s5_s[2];
    mid.num_z = s5_s[3];
    mid.degenerate = (s5_s[0] == '0);
  end

endmodule

`default_nettype wire

[src/tpi_fifo.sv]
// Short queue between the front and back pipelines.
`default_nettype none

module tpi_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  tpi_pkg::mid_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output tpi_pkg::mid_t rd_data
);

  tpi_pkg::mid_t mem [tpi_pkg::FIFO_DEPTH];
  logic [tpi_pkg::PTR_BITS-1:0] wptr;
  logic [tpi_pkg::PTR_BITS-1:0] rptr;
  logic [tpi_pkg::PTR_BITS:0] cnt;
  logic wr;
  logic rd;

  assign wr_ready = (cnt != (tpi_pkg::PTR_BITS+1)'(tpi_pkg::FIFO_DEPTH));
  assign rd_valid = (cnt != '0);
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      if (wr && !rd) begin
        cnt <= cnt + 1'b1;
      end else if (rd && !wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

[src/tpi_back.sv]
// Back pipeline: magnitudes, overflow test, restoring divider and output register.
`default_nettype none

module tpi_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tpi_pkg::mid_t mid,
  output logic          empty,
  input  logic          pop,
  output tpi_pkg::out_t point
);

  localparam int QB = tpi_pkg::QUO_BITS;
  localparam int RW = tpi_pkg::REM_BITS;
  localparam int SW = tpi_pkg::SUM_BITS;

  logic en;
  logic take;
  logic out_vld;

  logic [SW-1:0] nm [3];

  logic p1_vld;
  logic [SW-1:0] p1_mag [3];
  logic p1_neg [3];
  logic [SW-1:0] p1_dmag;
  logic p1_dg;

  logic dv [QB+1];
  logic [RW-1:0] rem [QB+1][3];
  logic [QB-1:0] q [QB+1][3];
  logic ng [QB+1][3];
  logic ov [QB+1][3];
  logic [SW-1:0] dm [QB+1];
  logic dg [QB+1];

  tpi_pkg::val_t vals [3];
  tpi_pkg::out_t res;

  assign en = !out_vld || pop;
  assign in_ready = en;
  assign take = in_valid && en;
  assign empty = !out_vld;

  always_comb begin
    nm[0] = mid.num_x;
    nm[1] = mid.num_y;
    nm[2] = mid.num_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      dv[0] <= 1'b0;
    end else if (en) begin
      p1_vld <= in_valid;
      dv[0] <= p1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p1_mag[k] <= nm[k][SW-1] ? -nm[k] : nm[k];
        p1_neg[k] <= nm[k][SW-1] ^ ~mid.den[SW-1];
      end
      p1_dmag <= mid.den[SW-1] ? -mid.den : mid.den;
      p1_dg <= mid.degenerate;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        rem[0][k] <= RW'(p1_mag[k]) << tpi_pkg::FRAC_BITS;
        ov[0][k] <= (RW'(p1_mag[k]) << tpi_pkg::FRAC_BITS) >= (RW'(p1_dmag) << QB);
        q[0][k] <= '0;
        ng[0][k] <= p1_neg[k];
      end
      dm[0] <= p1_dmag;
      dg[0] <= p1_dg;
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_div
    logic [RW-1:0] trial;
    logic [2:0] hit;

    assign trial = RW'(dm[s-1]) << (QB - s);

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        hit[k] = (rem[s-1][k] >= trial);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[s] <= 1'b0;
      end else if (en) begin
        dv[s] <= dv[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          rem[s][k] <= hit[k] ? rem[s-1][k] - trial : rem[s-1][k];
          q[s][k] <= q[s-1][k] | (QB'(hit[k]) << (QB - s));
          ng[s][k] <= ng[s-1][k];
          ov[s][k] <= ov[s-1][k];
        end
        dm[s] <= dm[s-1];
        dg[s] <= dg[s-1];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dg[QB]) begin
        vals[k] = '0;
      end else if (ov[QB][k]) begin
        vals[k] = ng[QB][k] ? tpi_pkg::VAL_MIN : tpi_pkg::VAL_MAX;
      end else if (ng[QB][k]) begin
        vals[k] = -{1'b0, q[QB][k]};
      end else begin
        vals[k] = {1'b0, q[QB][k]};
      end
    end
    res.pos_x = vals[0];
    res.pos_y = vals[1];
    res.pos_z = vals[2];
    res.degenerate = dg[QB];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= dv[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      point <= res;
    end
  end

`ifndef SYNTH
  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    out_vld && point.degenerate |-> point.pos_x == '0 && point.pos_y == '0
      && point.pos_z == '0)
    else $error("degenerate result with nonzero coordinates");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(p1_vld) && $stable(dv[0]) && $stable(dv[QB]))
    else $error("divider pipeline moved while stalled");

  a_take_enters: assert property (@(posedge clk) disable iff (rst)
    take |=> p1_vld)
    else $error("accepted item did not enter the divider pipeline");
`endif

endmodule

`default_nettype wire

[src/three_plane_intersection.sv]
// Top level of the three-plane intersection block.
`default_nettype none

// Takes three planes (normal and distance, signed Q12.12) per item and returns the
// point where they meet, each coordinate truncated toward zero and saturated to
// Q12.12; a zero triple product sets degenerate and gives zero coordinates. One item
// is accepted every clock cycle while full is low. From push to the result ports an
// item passes five front stages of exact products and sums, the queue, two setup
// stages, 23 restoring divider stages (one quotient bit per stage, three coordinates
// side by side) and the output register. The queue lets the front keep accepting
// items while a result waits to be popped.
module three_plane_intersection (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  tpi_pkg::in_t  planes,
  output logic          empty,
  input  logic          pop,
  output tpi_pkg::out_t point
);

  logic          f_valid;
  logic          f_ready;
  tpi_pkg::mid_t f_data;
  logic          b_valid;
  logic          b_ready;
  tpi_pkg::mid_t b_data;

  tpi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .planes    (planes),
    .mid_valid (f_valid),
    .mid_ready (f_ready),
    .mid       (f_data)
  );

  tpi_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  tpi_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (b_valid),
    .in_ready (b_ready),
    .mid      (b_data),
    .empty    (empty),
    .pop      (pop),
    .point    (point)
  );

endmodule

`default_nettype wire
